// File: sv/oaht_pkg.sv
`default_nettype none
package oaht_pkg;

    // Table geometry. The home slot is the low key bits and the probe step wraps
    // by truncation, so the size stays a power of two.
    localparam int TABLE_SIZE = 128;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    read_value;
        logic [LIVE_W-1:0]   live_count;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_APPLY
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic probe;
        logic apply;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic probe_end;
    } t_dp_sts;

endpackage
`default_nettype wire

// File: sv/oaht_ctrl.sv
`default_nettype none
module oaht_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_out_ready,
    input  wire oaht_pkg::t_dp_sts i_sts,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output oaht_pkg::t_dp_cmd      o_cmd
);
    import oaht_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PROBE;
                end
            end
            S_PROBE: begin
                o_cmd.probe = 1'b1;
                if (i_sts.probe_end) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                // hold until the result register can take the new item
                if (out_free) begin
                    o_cmd.apply = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// File: sv/oaht_dp.sv
`default_nettype none
module oaht_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire oaht_pkg::t_dp_cmd  i_cmd,
    input  wire oaht_pkg::t_in_item i_item,
    output oaht_pkg::t_dp_sts       o_sts,
    output oaht_pkg::t_out_item     o_item
);
    import oaht_pkg::*;

    // key/value store, {key, value} per slot
    logic [KEY_W+VAL_W-1:0] r_mem [TABLE_SIZE];
    logic [KEY_W+VAL_W-1:0] r_rd_data;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;

    // slot flags in flops, cleared by reset
    logic [TABLE_SIZE-1:0] r_used;
    logic [TABLE_SIZE-1:0] r_dead;
    logic [CNT_W-1:0]      r_count;

    // operation in flight
    logic [CMD_W-1:0] r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic [IDX_W-1:0] r_pos;
    logic [IDX_W-1:0] r_k;
    logic             r_free_vld;
    logic [IDX_W-1:0] r_free_pos;
    logic             r_hit_vld;
    logic [IDX_W-1:0] r_hit_pos;
    logic [VAL_W-1:0] r_hit_value;

    t_out_item r_out;

    logic [IDX_W-1:0] next_pos;
    logic             slot_used;
    logic             slot_dead;
    logic             key_match;
    logic             last_probe;

    logic             fill_en;
    logic             kill_en;
    logic [CNT_W-1:0] new_count;
    t_out_item        out_nxt;

    // triangular step: the k-th move advances by k
    assign next_pos   = IDX_W'(r_pos + r_k + IDX_W'(1));
    assign slot_used  = r_used[r_pos];
    assign slot_dead  = r_dead[r_pos];
    assign key_match  = r_rd_data[KEY_W+VAL_W-1:VAL_W] == r_key;
    assign last_probe = r_k == IDX_W'(TABLE_SIZE - 1);

    assign o_sts.probe_end = !slot_used || (!slot_dead && key_match) || last_probe;

    // read port runs every cycle; r_rd_data always matches r_pos while probing
    always_comb begin
        if (i_cmd.load) begin
            rd_addr = i_item.key[IDX_W-1:0];
        end else if (i_cmd.probe) begin
            rd_addr = next_pos;
        end else begin
            rd_addr = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        if (wr_en) begin
            r_mem[wr_addr] <= {r_key, r_value};
        end
    end

    // apply step
    always_comb begin
        wr_en             = 1'b0;
        wr_addr           = r_hit_pos;
        fill_en           = 1'b0;
        kill_en           = 1'b0;
        new_count         = r_count;
        out_nxt.status    = STS_MISS;
        out_nxt.read_value = '0;
        case (r_cmd)
            CMD_INSERT: begin
                if (r_hit_vld) begin
                    wr_en          = 1'b1;
                    out_nxt.status = STS_OK;
                end else if (r_free_vld) begin
                    wr_en          = 1'b1;
                    wr_addr        = r_free_pos;
                    fill_en        = 1'b1;
                    new_count      = CNT_W'(r_count + CNT_W'(1));
                    out_nxt.status = STS_OK;
                end else begin
                    out_nxt.status = STS_FULL;
                end
            end
            CMD_DELETE: begin
                if (r_hit_vld) begin
                    kill_en        = 1'b1;
                    out_nxt.status = STS_OK;
                    if (r_count != '0) begin
                        new_count = CNT_W'(r_count - CNT_W'(1));
                    end
                end
            end
            default: begin
                // search, and the unused code that acts as one
                if (r_hit_vld) begin
                    out_nxt.status     = STS_OK;
                    out_nxt.read_value = r_hit_value;
                end
            end
        endcase
        wr_en              = wr_en && i_cmd.apply;
        out_nxt.live_count = LIVE_W'(new_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_dead     <= '0;
            r_count    <= '0;
            r_free_vld <= 1'b0;
            r_hit_vld  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_free_vld <= 1'b0;
                r_hit_vld  <= 1'b0;
            end else if (i_cmd.probe) begin
                if ((!slot_used || slot_dead) && !r_free_vld) begin
                    r_free_vld <= 1'b1;
                end
                if (slot_used && !slot_dead && key_match) begin
                    r_hit_vld <= 1'b1;
                end
            end else if (i_cmd.apply) begin
                r_count <= new_count;
                if (fill_en) begin
                    r_used[r_free_pos] <= 1'b1;
                    r_dead[r_free_pos] <= 1'b0;
                end
                if (kill_en) begin
                    r_dead[r_hit_pos] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_item.cmd;
            r_key   <= i_item.key;
            r_value <= i_item.value;
            r_pos   <= i_item.key[IDX_W-1:0];
            r_k     <= '0;
        end else if (i_cmd.probe) begin
            r_pos <= next_pos;
            r_k   <= IDX_W'(r_k + IDX_W'(1));
            if ((!slot_used || slot_dead) && !r_free_vld) begin
                r_free_pos <= r_pos;
            end
            if (slot_used && !slot_dead && key_match) begin
                r_hit_pos   <= r_pos;
                r_hit_value <= r_rd_data[VAL_W-1:0];
            end
        end
        if (i_cmd.apply) begin
            r_out <= out_nxt;
        end
    end

    assign o_item = r_out;

endmodule
`default_nettype wire

// File: sv/open_address_hash_table.sv
// Open-addressing key/value table, 128 slots, triangular probing.
// Flow: an accepted item walks its probe path (1 to 128 probes, one slot per
//   cycle through the key/value RAM port); the update and the result register
//   follow once that register is free, and only then is a new item accepted.
// Reset (i_rst_n low, synchronous): used/tombstone flags, live count and control
//   clear at once; key/value RAM is left as is, so no clearing pass is needed.
`default_nettype none
module open_address_hash_table (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // request channel
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire oaht_pkg::t_in_item  i_in_item,
    // result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output oaht_pkg::t_out_item      o_out_item
);
    import oaht_pkg::*;

    t_dp_cmd s_cmd;
    t_dp_sts s_sts;

    // Controller: IDLE takes an item, PROBE walks the path one slot a cycle,
    // APPLY commits the update and loads the result register once it is free.
    oaht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (s_sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (s_cmd)
    );

    // Datapath: slot flags, key/value RAM, probe position and step, first free
    // slot and hit tracking, live count and the result register.
    oaht_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (s_cmd),
        .i_item  (i_in_item),
        .o_sts   (s_sts),
        .o_item  (o_out_item)
    );

    // at most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({s_cmd.load, s_cmd.probe, s_cmd.apply}))
        else $error("datapath commands overlap");

    // an accepted item always starts a probe walk next cycle
    a_accept_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> s_cmd.probe)
        else $error("accepted item did not start probing");

    // a miss or a full table never carries a read value
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != STS_OK) |-> o_out_item.read_value == '0)
        else $error("nonzero read value without a hit");

    // live count never exceeds the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.live_count <= LIVE_W'(TABLE_SIZE))
        else $error("live count out of range");

endmodule
`default_nettype wire
